### design/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
// No dependencies; used by the controller, the datapath and the top level.
package mhpq_pkg;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_DELETE  = 3'd1;
    localparam logic [2:0] OP_SORT    = 3'd2;
    localparam logic [2:0] OP_HEAPIFY = 3'd3;
    localparam logic [2:0] OP_DUMP    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [6:0] LIMIT_RESET = 7'd32;

    localparam logic [4:0] CMD_NONE       = 5'd0;
    localparam logic [4:0] CMD_CAPTURE    = 5'd1;
    localparam logic [4:0] CMD_INS_START  = 5'd2;
    localparam logic [4:0] CMD_SU_READ    = 5'd3;
    localparam logic [4:0] CMD_SU_STEP    = 5'd4;
    localparam logic [4:0] CMD_PLACE      = 5'd5;
    localparam logic [4:0] CMD_SD_READ    = 5'd6;
    localparam logic [4:0] CMD_SD_STEP    = 5'd7;
    localparam logic [4:0] CMD_DEL_START  = 5'd8;
    localparam logic [4:0] CMD_SORT_START = 5'd9;
    localparam logic [4:0] CMD_SORT_DEC   = 5'd10;
    localparam logic [4:0] CMD_XRD        = 5'd11;
    localparam logic [4:0] CMD_XLD        = 5'd12;
    localparam logic [4:0] CMD_HEAP_START = 5'd13;
    localparam logic [4:0] CMD_HEAP_NEXT  = 5'd14;
    localparam logic [4:0] CMD_HEAP_LD    = 5'd15;
    localparam logic [4:0] CMD_DUMP_START = 5'd16;
    localparam logic [4:0] CMD_DUMP_RD    = 5'd17;
    localparam logic [4:0] CMD_DUMP_LD    = 5'd18;
    localparam logic [4:0] CMD_RES        = 5'd19;
    localparam logic [4:0] CMD_EMIT       = 5'd20;

    typedef struct packed {
        logic signed [31:0] key;
        logic [7:0]         tag;
    } entry_t;

    typedef struct packed {
        logic [4:0] code;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic       empty;
        logic       full;
        logic       at_root;
        logic       has_child;
        logic       move_up;
        logic       move_down;
        logic       n_gt1;
        logic       iter_nz;
        logic       res_last;
        logic       out_free;
    } stat_t;

endpackage

### design/max_heap_priority_queue.sv
// Top level of the max-heap priority queue: stream ports around controller and datapath.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_dp.
//
// One input transaction carries an opcode (insert, delete root, heap sort,
// heapify, dump) with a key and a tag. Each opcode gives one output
// transaction, except a dump of a non-empty heap, which gives one per live
// entry in array order with tlast on the final one. The limit register is
// written through cfg_we and cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce. The block
// works on one transaction at a time; s_tready is high only while the
// controller waits for a new opcode. Entries live in a memory with two
// registered read ports and one write port, so each heap level takes a
// read state and a compare state. The result leaves from an output
// register, so it may wait on m_tready while the next work proceeds up to
// its own result. Reset empties the heap and sets the limit to 32; memory
// contents are not cleared. A stalled receiver holds the result and stops
// the block at its next result.
module max_heap_priority_queue #(
    parameter int CAPACITY = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // opcode[2:0], key[34:3], tag[42:35], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status[1:0], key_out[33:2], tag_out[41:34], count[48:42]
    output logic        m_tlast
);
    import mhpq_pkg::*;

    cmd_t               cmd;
    stat_t              stat;
    logic [1:0]         out_status;
    logic signed [31:0] out_key;
    logic [7:0]         out_tag;
    logic [6:0]         out_count;

    mhpq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_data    (s_tdata[42:0]),
        .cmd        (cmd),
        .stat       (stat),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_key    (out_key),
        .out_tag    (out_tag),
        .out_count  (out_count),
        .out_last   (m_tlast)
    );

    assign m_tdata = {7'd0, out_count, out_tag, out_key, out_status};

endmodule

### design/mhpq_ctrl.sv
// Controller state machine of the max-heap priority queue.
// Depends on mhpq_pkg; drives mhpq_dp through command and status structs.
module mhpq_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mhpq_pkg::stat_t stat,
    output mhpq_pkg::cmd_t  cmd
);
    import mhpq_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SU_RD    = 4'd2;
    localparam logic [3:0] S_SU_CMP   = 4'd3;
    localparam logic [3:0] S_FIN      = 4'd4;
    localparam logic [3:0] S_SORT_CHK = 4'd5;
    localparam logic [3:0] S_XRD      = 4'd6;
    localparam logic [3:0] S_XLD      = 4'd7;
    localparam logic [3:0] S_SD_RD    = 4'd8;
    localparam logic [3:0] S_SD_CMP   = 4'd9;
    localparam logic [3:0] S_HEAP_CHK = 4'd10;
    localparam logic [3:0] S_HEAP_LD  = 4'd11;
    localparam logic [3:0] S_DUMP_RD  = 4'd12;
    localparam logic [3:0] S_DUMP_LD  = 4'd13;
    localparam logic [3:0] S_EMIT     = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] sift_ret;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        priority if (stat.opcode == OP_DELETE)
            sift_ret = S_EMIT;
        else if (stat.opcode == OP_SORT)
            sift_ret = S_SORT_CHK;
        else
            sift_ret = S_HEAP_CHK;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.code   = CMD_NONE;
        cmd.status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.code   = CMD_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_EMIT;
                cmd.code   = CMD_RES;
                unique case (stat.opcode)
                    OP_INSERT:
                    begin
                        if (stat.full)
                            cmd.status = ST_FULL;
                        else
                        begin
                            cmd.code   = CMD_INS_START;
                            state_next = S_SU_RD;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (stat.empty)
                            cmd.status = ST_EMPTY;
                        else
                        begin
                            cmd.code   = CMD_DEL_START;
                            state_next = S_XRD;
                        end
                    end
                    OP_SORT:
                    begin
                        cmd.code   = CMD_SORT_START;
                        state_next = S_SORT_CHK;
                    end
                    OP_HEAPIFY:
                    begin
                        if (stat.empty)
                            cmd.status = ST_EMPTY;
                        else
                        begin
                            cmd.code   = CMD_HEAP_START;
                            state_next = S_HEAP_CHK;
                        end
                    end
                    OP_DUMP:
                    begin
                        if (stat.empty)
                            cmd.status = ST_EMPTY;
                        else
                        begin
                            cmd.code   = CMD_DUMP_START;
                            state_next = S_DUMP_RD;
                        end
                    end
                    default:
                    begin
                        cmd.status = ST_OK;
                    end
                endcase
            end
            S_SU_RD:
            begin
                if (stat.at_root)
                begin
                    cmd.code   = CMD_PLACE;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.code   = CMD_SU_READ;
                    state_next = S_SU_CMP;
                end
            end
            S_SU_CMP:
            begin
                if (stat.move_up)
                begin
                    cmd.code   = CMD_SU_STEP;
                    state_next = S_SU_RD;
                end
                else
                begin
                    cmd.code   = CMD_PLACE;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.code   = CMD_RES;
                state_next = S_EMIT;
            end
            S_SORT_CHK:
            begin
                if (stat.n_gt1)
                begin
                    cmd.code   = CMD_SORT_DEC;
                    state_next = S_XRD;
                end
                else
                begin
                    cmd.code   = CMD_RES;
                    state_next = S_EMIT;
                end
            end
            S_XRD:
            begin
                cmd.code   = CMD_XRD;
                state_next = S_XLD;
            end
            S_XLD:
            begin
                cmd.code   = CMD_XLD;
                state_next = S_SD_RD;
            end
            S_SD_RD:
            begin
                if (stat.has_child)
                begin
                    cmd.code   = CMD_SD_READ;
                    state_next = S_SD_CMP;
                end
                else
                begin
                    cmd.code   = CMD_PLACE;
                    state_next = sift_ret;
                end
            end
            S_SD_CMP:
            begin
                if (stat.move_down)
                begin
                    cmd.code   = CMD_SD_STEP;
                    state_next = S_SD_RD;
                end
                else
                begin
                    cmd.code   = CMD_PLACE;
                    state_next = sift_ret;
                end
            end
            S_HEAP_CHK:
            begin
                if (stat.iter_nz)
                begin
                    cmd.code   = CMD_HEAP_NEXT;
                    state_next = S_HEAP_LD;
                end
                else
                begin
                    cmd.code   = CMD_RES;
                    state_next = S_EMIT;
                end
            end
            S_HEAP_LD:
            begin
                cmd.code   = CMD_HEAP_LD;
                state_next = S_SD_RD;
            end
            S_DUMP_RD:
            begin
                cmd.code   = CMD_DUMP_RD;
                state_next = S_DUMP_LD;
            end
            S_DUMP_LD:
            begin
                cmd.code   = CMD_DUMP_LD;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.code = CMD_EMIT;
                    if (stat.opcode == OP_DUMP && !stat.res_last)
                        state_next = S_DUMP_RD;
                    else
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

### design/mhpq_dp.sv
// Datapath of the max-heap priority queue: entry memory, indices and result register.
// Depends on mhpq_pkg; sequenced by mhpq_ctrl.
module mhpq_dp #(
    parameter int CAPACITY = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata,
    input  logic [42:0]        in_data,
    input  mhpq_pkg::cmd_t     cmd,
    output mhpq_pkg::stat_t    stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         out_status,
    output logic signed [31:0] out_key,
    output logic [7:0]         out_tag,
    output logic [6:0]         out_count,
    output logic               out_last
);
    import mhpq_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = IW + 2;
    localparam logic [6:0] CAP7 = 7'(CAPACITY);

    entry_t mem [CAPACITY];

    logic [6:0]    limit_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] iter_reg;
    logic [IW-1:0] pos_reg;
    logic [2:0]    op_reg;
    entry_t        in_reg;
    entry_t        cur_reg;
    entry_t        rd0_reg;
    entry_t        rd1_reg;
    logic [1:0]    res_status_reg;
    entry_t        res_entry_reg;
    logic          res_last_reg;
    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    entry_t        out_entry_reg;
    logic [6:0]    out_count_reg;
    logic          out_last_reg;

    logic [IW-1:0] raddr0;
    logic [IW-1:0] raddr1;
    logic          we;
    logic [IW-1:0] waddr;
    entry_t        wdata;
    logic [6:0]    eff_limit;
    logic [XW-1:0] left_x;
    logic [XW-1:0] right_x;
    logic [XW-1:0] n_x;
    logic          right_ok;
    logic          take_right;
    entry_t        big_entry;
    logic [IW-1:0] big_idx;
    logic [IW-1:0] parent_idx;
    logic [CW-1:0] iter_dec;
    logic          out_free;

    assign eff_limit  = (limit_reg > CAP7) ? CAP7 : limit_reg;
    assign left_x     = {1'b0, pos_reg, 1'b1};
    assign right_x    = left_x + XW'(1);
    assign n_x        = XW'(n_reg);
    assign right_ok   = right_x < n_x;
    assign take_right = right_ok && !(rd0_reg.key > rd1_reg.key);
    assign big_entry  = take_right ? rd1_reg : rd0_reg;
    assign big_idx    = take_right ? right_x[IW-1:0] : left_x[IW-1:0];
    assign parent_idx = IW'((pos_reg - IW'(1)) >> 1);
    assign iter_dec   = iter_reg - CW'(1);
    assign out_free   = !out_valid_reg || out_ready;

    assign stat.opcode    = op_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (7'(count_reg) >= eff_limit);
    assign stat.at_root   = (pos_reg == '0);
    assign stat.has_child = left_x < n_x;
    assign stat.move_up   = cur_reg.key > rd0_reg.key;
    assign stat.move_down = big_entry.key > cur_reg.key;
    assign stat.n_gt1     = n_reg > CW'(1);
    assign stat.iter_nz   = (iter_reg != '0);
    assign stat.res_last  = res_last_reg;
    assign stat.out_free  = out_free;

    always_comb
    begin
        raddr0 = '0;
        raddr1 = '0;
        we     = 1'b0;
        waddr  = pos_reg;
        wdata  = cur_reg;
        unique case (cmd.code)
            CMD_SU_READ:   raddr0 = parent_idx;
            CMD_SD_READ:
            begin
                raddr0 = left_x[IW-1:0];
                raddr1 = right_x[IW-1:0];
            end
            CMD_XRD:       raddr1 = n_reg[IW-1:0];
            CMD_HEAP_NEXT: raddr0 = iter_dec[IW-1:0];
            CMD_DUMP_RD:   raddr0 = iter_reg[IW-1:0];
            CMD_SU_STEP:
            begin
                we    = 1'b1;
                wdata = rd0_reg;
            end
            CMD_PLACE:     we = 1'b1;
            CMD_SD_STEP:
            begin
                we    = 1'b1;
                wdata = big_entry;
            end
            CMD_XLD:
            begin
                we    = 1'b1;
                waddr = n_reg[IW-1:0];
                wdata = rd0_reg;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd0_reg <= mem[raddr0];
        rd1_reg <= mem[raddr1];
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.code)
            CMD_CAPTURE:
            begin
                op_reg      <= in_data[2:0];
                in_reg.key  <= in_data[34:3];
                in_reg.tag  <= in_data[42:35];
            end
            CMD_INS_START:
            begin
                pos_reg <= count_reg[IW-1:0];
                cur_reg <= in_reg;
            end
            CMD_SU_STEP:   pos_reg <= parent_idx;
            CMD_SD_STEP:   pos_reg <= big_idx;
            CMD_XLD:
            begin
                cur_reg        <= rd1_reg;
                pos_reg        <= '0;
                res_entry_reg  <= rd0_reg;
                res_status_reg <= ST_OK;
                res_last_reg   <= 1'b1;
            end
            CMD_HEAP_NEXT: pos_reg <= iter_dec[IW-1:0];
            CMD_HEAP_LD:   cur_reg <= rd0_reg;
            CMD_DUMP_LD:
            begin
                res_entry_reg  <= rd0_reg;
                res_status_reg <= ST_OK;
                res_last_reg   <= (iter_reg + CW'(1) == count_reg);
            end
            CMD_RES:
            begin
                res_entry_reg  <= '0;
                res_status_reg <= cmd.status;
                res_last_reg   <= 1'b1;
            end
            CMD_EMIT:
            begin
                out_status_reg <= res_status_reg;
                out_entry_reg  <= res_entry_reg;
                out_count_reg  <= 7'(count_reg);
                out_last_reg   <= res_last_reg;
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            n_reg         <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            unique case (cmd.code)
                CMD_INS_START:  count_reg <= count_reg + CW'(1);
                CMD_DEL_START:
                begin
                    count_reg <= count_reg - CW'(1);
                    n_reg     <= count_reg - CW'(1);
                end
                CMD_SORT_START: n_reg <= count_reg;
                CMD_SORT_DEC:   n_reg <= n_reg - CW'(1);
                CMD_HEAP_START:
                begin
                    n_reg    <= count_reg;
                    iter_reg <= count_reg >> 1;
                end
                CMD_HEAP_NEXT:  iter_reg <= iter_dec;
                CMD_DUMP_START: iter_reg <= '0;
                CMD_DUMP_LD:    iter_reg <= iter_reg + CW'(1);
                default:
                begin
                    n_reg <= n_reg;
                end
            endcase
            if (cmd.code == CMD_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_key    = out_entry_reg.key;
    assign out_tag    = out_entry_reg.tag;
    assign out_count  = out_count_reg;
    assign out_last   = out_last_reg;

endmodule

### design/mhpq_checker.sv
// Port-level checker for the max-heap priority queue, bound to the top level.
// Depends only on the ports of max_heap_priority_queue.
module mhpq_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic        m_tlast
);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input taken while a transaction is in progress.");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Stalled result changed.");

    a_error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tlast)
        else $error("Error status on a non-final result.");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[48:42] <= 7'd64 && m_tdata[1:0] != 2'd3)
        else $error("Result count or status out of range.");

    a_no_result_when_idle_input: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !m_tvalid || $past(m_tvalid))
        else $error("Result appeared in the cycle after input was taken.");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
